// File: rtl/window_median_spectral_distance_unit_defines.svh
// Assertion macros shared by the windowed median distance RTL
`ifndef WINDOW_MEDIAN_SPECTRAL_DISTANCE_UNIT_DEFINES_SVH
`define WINDOW_MEDIAN_SPECTRAL_DISTANCE_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define WMSD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wmsd check failed");
// implication checked in the cycle after the antecedent
`define WMSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wmsd check failed");
`endif

// File: rtl/wmsd_pkg.sv
// Package: shared types and constants of the windowed median distance unit
package wmsd_pkg;
  localparam int DIST_W = 25;
  localparam int POS_W  = 10;
  localparam int PIX_W  = 64;
  localparam int CFG_W  = 11;
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_BANDS  = 2'd3;
  // request kinds on func
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // control towards the sorter chain
  typedef struct packed {
    logic clear;
    logic insert;
  } sort_ctl_t;
endpackage

// File: rtl/wmsd_isqrt.sv
// Multi-cycle truncating square root, one result bit per step
module wmsd_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [49:0]                radicand,
  output logic                       done,
  output logic [wmsd_pkg::DIST_W-1:0] root
);
  import wmsd_pkg::*;
  logic [49:0] rem;
  logic [49:0] res;
  logic [49:0] bitv;
  logic        busy;
  logic [49:0] trial;

  // restoring square root, one result bit per cycle
  assign trial = res + bitv;
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= radicand;
        res  <= '0;
        bitv <= 50'd1 << 48;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  // after the last step res holds the finished root
  assign root = DIST_W'(res);
endmodule

// File: rtl/wmsd_sort_cell.sv
// One cell of the insertion sorter chain
module wmsd_sort_cell (
  input  logic                        clk,
  input  wmsd_pkg::sort_ctl_t         ctl,
  input  logic [wmsd_pkg::DIST_W-1:0] value,
  input  logic [wmsd_pkg::DIST_W-1:0] prev_val,
  input  logic                        prev_full,
  input  logic                        prev_gt,
  output logic [wmsd_pkg::DIST_W-1:0] val,
  output logic                        full,
  output logic                        gt
);
  import wmsd_pkg::*;
  // this cell holds a value above the incoming one
  assign gt = full && (val > value);
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      full <= 1'b0;
    end else if (ctl.insert) begin
      if (prev_gt) begin
        val  <= prev_val;
        full <= prev_full;
      end else if (prev_full && (gt || !full)) begin
        // only the insertion point takes the new value: the first cell above it, or the first empty one
        val  <= value;
        full <= 1'b1;
      end
    end
  end
endmodule

// File: rtl/window_median_spectral_distance_unit.sv
// Top level: windowed median spectral distance over a line store
// Usage:
//  Pixels enter on in_valid/in_ready in raster order; func=1 is a drain
//  request that releases the next finished result. Configuration is written
//  through cfg_we/cfg_index/cfg_data while the unit is idle; a write restarts
//  the frame. Each result leaves on out_valid/out_ready.
//  Flow: a request is taken while the unit is idle. Each finished result then
//  steps through every window position (line store read, band sum, 25-step
//  square root, sorter insert) after window set-up, followed by median pick
//  and hand-off; the square root unit bounds the work per position. Up to
//  four results may follow one pixel request.
//  Reset clears positions and registers to their reset values; the line
//  store is left uninitialised and read only where written this frame.
//  While out_ready is low the finished result is held and no new request is
//  taken until it is accepted.
module window_median_spectral_distance_unit #(
  parameter int MAX_RADIUS = 3,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [15:0] band_a,
  input  logic [15:0] band_b,
  input  logic [15:0] band_c,
  input  logic [15:0] band_d,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [24:0] median_distance,
  output logic [9:0]  pixel_row,
  output logic [9:0]  pixel_col,
  output logic        frame_last
);
  import wmsd_pkg::*;
  `include "window_median_spectral_distance_unit_defines.svh"

  localparam int SLOTS = 2 * MAX_RADIUS + 1;
  localparam int NWIN  = SLOTS * SLOTS;
  localparam int SW    = $clog2(SLOTS);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = SLOTS * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(NWIN + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_CENT  = 9'b000000100,
    S_RD    = 9'b000001000,
    S_SUM   = 9'b000010000,
    S_SQRT  = 9'b000100000,
    S_INS   = 9'b001000000,
    S_MED   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;
  state_t state;

  // configuration
  logic [1:0]  window_radius;
  logic [10:0] image_width, image_height;
  logic [2:0]  bands_in_use;
  logic [2:0]  eff_r;
  logic [12:0] eff_w, eff_h;
  logic [2:0]  eff_b;
  always_comb begin
    eff_r = (32'(window_radius) > MAX_RADIUS) ? 3'(MAX_RADIUS) : 3'(window_radius);
    eff_w = (image_width == 0) ? 13'd1 :
            (32'(image_width) > MAX_WIDTH) ? 13'(MAX_WIDTH) : 13'(image_width);
    eff_h = (image_height == 0) ? 13'd1 :
            (32'(image_height) > MAX_HEIGHT) ? 13'(MAX_HEIGHT) : 13'(image_height);
    eff_b = (bands_in_use == 0) ? 3'd1 : (bands_in_use > 3'd4) ? 3'd4 : bands_in_use;
  end

  // positions
  logic [RW-1:0] in_row, out_row;
  logic [CW-1:0] in_col, out_col;
  logic [SW-1:0] in_slot, out_slot;
  logic          in_done;
  logic [2:0]    budget;
  logic          was_pixel;

  // completeness of the next result
  logic [13:0] tr, tc;
  logic        complete;
  always_comb begin
    tr = ({1'b0, 13'(out_row)} + 14'(eff_r) > 14'(eff_h) - 14'd1) ?
         14'(eff_h) - 14'd1 : {1'b0, 13'(out_row)} + 14'(eff_r);
    tc = ({1'b0, 13'(out_col)} + 14'(eff_r) > 14'(eff_w) - 14'd1) ?
         14'(eff_w) - 14'd1 : {1'b0, 13'(out_col)} + 14'(eff_r);
    complete = in_done || (14'(in_row) > tr) || (14'(in_row) == tr && 14'(in_col) > tc);
  end

  // line store
  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [PIX_W-1:0] wr_data;
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // window scan
  logic [RW:0]      wr_row, wr_lo, wr_hi;
  logic [CW:0]      wc_col, wc_lo, wc_hi;
  logic [SW-1:0]    wr_slot, lo_back;
  logic [PIX_W-1:0] centre;
  logic [NW-1:0]    count;
  logic [49:0]      sum_sq;
  logic             sq_start, sq_done;
  logic [DIST_W-1:0] sq_root;
  sort_ctl_t        sctl;

  // rows between the first window row and the centre row
  assign lo_back = SW'(out_row - RW'(wr_lo));

  function automatic logic [33:0] band_sq(input logic [15:0] a, input logic [15:0] b);
    logic [33:0] d;
    d = (a >= b) ? 34'(a - b) : 34'(b - a);
    return d * d;
  endfunction

  logic [35:0] band_sum;
  always_comb begin
    band_sum = 36'(band_sq(rd_data[15:0], centre[15:0]));
    if (eff_b > 3'd1) band_sum = band_sum + 36'(band_sq(rd_data[31:16], centre[31:16]));
    if (eff_b > 3'd2) band_sum = band_sum + 36'(band_sq(rd_data[47:32], centre[47:32]));
    if (eff_b > 3'd3) band_sum = band_sum + 36'(band_sq(rd_data[63:48], centre[63:48]));
  end

  always_comb begin
    wr_en   = (state == S_IDLE) && in_valid && (func == FUNC_PIXEL);
    wr_addr = AW'(in_slot) * AW'(MAX_WIDTH) + AW'(in_col);
    wr_data = {band_d, band_c, band_b, band_a};
    if (state == S_CHECK)
      rd_addr = AW'(out_slot) * AW'(MAX_WIDTH) + AW'(out_col);
    else
      rd_addr = AW'(wr_slot) * AW'(MAX_WIDTH) + AW'(wc_col);
  end

  wmsd_isqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sum_sq),
    .done(sq_done), .root(sq_root)
  );

  // sorter chain; the head cell has nothing ahead of it to wait on
  logic [DIST_W-1:0] cv [NWIN];
  logic              cf [NWIN];
  logic              cg [NWIN];
  logic [DIST_W-1:0] cur;
  genvar g;
  generate
    for (g = 0; g < NWIN; g++) begin : g_cell
      if (g == 0) begin : g_first
        wmsd_sort_cell u_cell (
          .clk(clk), .ctl(sctl), .value(cur), .prev_val('0), .prev_full(1'b1),
          .prev_gt(1'b0), .val(cv[g]), .full(cf[g]), .gt(cg[g])
        );
      end else begin : g_rest
        wmsd_sort_cell u_cell (
          .clk(clk), .ctl(sctl), .value(cur), .prev_val(cv[g-1]),
          .prev_full(cf[g-1]), .prev_gt(cg[g-1]), .val(cv[g]), .full(cf[g]),
          .gt(cg[g])
        );
      end
    end
  endgenerate

  // median pick: let the last insert settle, then two reads
  logic [1:0]        med_step;
  logic [DIST_W-1:0] mid_a;
  logic [DIST_W-1:0] res_val;
  logic              is_last;
  assign is_last = (13'(out_row) + 13'd1 >= eff_h) && (13'(out_col) + 13'd1 >= eff_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      window_radius <= 2'd1;
      image_width <= 11'd1024;
      image_height <= 11'd1024;
      bands_in_use <= 3'd4;
      in_row <= '0; in_col <= '0; in_slot <= '0;
      out_row <= '0; out_col <= '0; out_slot <= '0;
      in_done <= 1'b0;
      out_valid <= 1'b0;
      sq_start <= 1'b0;
      sctl <= '{clear: 1'b1, insert: 1'b0};
      budget <= '0;
      was_pixel <= 1'b0;
    end else begin
      sq_start <= 1'b0;
      sctl <= '{clear: 1'b0, insert: 1'b0};
      if (cfg_we) begin
        case (cfg_index)
          REG_RADIUS: window_radius <= cfg_data[1:0];
          REG_WIDTH:  image_width <= cfg_data;
          REG_HEIGHT: image_height <= cfg_data;
          REG_BANDS:  bands_in_use <= cfg_data[2:0];
          default: ;
        endcase
        in_row <= '0; in_col <= '0; in_slot <= '0;
        out_row <= '0; out_col <= '0; out_slot <= '0;
        in_done <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            budget <= 3'd4;
            was_pixel <= (func == FUNC_PIXEL);
            state <= S_CHECK;
            if (func == FUNC_PIXEL) begin
              // new frame drops results still pending
              if (in_done) begin
                out_row <= '0; out_col <= '0; out_slot <= '0;
              end
              if (13'(in_row) + 13'd1 >= eff_h && 13'(in_col) + 13'd1 >= eff_w) begin
                in_row <= '0; in_col <= '0; in_slot <= '0; in_done <= 1'b1;
              end else if (13'(in_col) + 13'd1 >= eff_w) begin
                in_col <= '0; in_row <= in_row + 1'b1; in_done <= 1'b0;
                in_slot <= (32'(in_slot) == SLOTS - 1) ? '0 : in_slot + 1'b1;
              end else begin
                in_col <= in_col + 1'b1; in_done <= 1'b0;
              end
            end
          end
        end
        S_CHECK: begin
          // centre read issued on this cycle
          if (complete && budget != 0) begin
            wr_lo <= ({1'b0, out_row} > (RW+1)'(eff_r)) ?
                     {1'b0, out_row} - (RW+1)'(eff_r) : '0;
            wr_hi <= ((RW+2)'(out_row) + (RW+2)'(eff_r) + 1 > (RW+2)'(eff_h)) ?
                     (RW+1)'(eff_h - 13'd1) : {1'b0, out_row} + (RW+1)'(eff_r);
            wc_lo <= ({1'b0, out_col} > (CW+1)'(eff_r)) ?
                     {1'b0, out_col} - (CW+1)'(eff_r) : '0;
            wc_hi <= ((CW+2)'(out_col) + (CW+2)'(eff_r) + 1 > (CW+2)'(eff_w)) ?
                     (CW+1)'(eff_w - 13'd1) : {1'b0, out_col} + (CW+1)'(eff_r);
            count <= '0;
            sctl <= '{clear: 1'b1, insert: 1'b0};
            state <= S_CENT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_CENT: begin
          centre <= rd_data;
          wr_row <= wr_lo;
          wc_col <= wc_lo;
          // slot of the first window row, stepping back round the ring
          wr_slot <= (out_slot >= lo_back) ? out_slot - lo_back :
                     SW'(32'(out_slot) + SLOTS - 32'(lo_back));
          state <= S_RD;
        end
        S_RD: state <= S_SUM;
        S_SUM: begin
          sum_sq <= {band_sum[33:0], 16'd0};
          sq_start <= 1'b1;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_done) begin
            cur <= (eff_r == 0) ? '0 : sq_root;
            state <= S_INS;
          end
        end
        S_INS: begin
          sctl <= '{clear: 1'b0, insert: 1'b1};
          count <= count + 1'b1;
          if (wc_col == wc_hi) begin
            wc_col <= wc_lo;
            if (wr_row == wr_hi) begin
              med_step <= 2'd0;
              state <= S_MED;
            end else begin
              wr_row <= wr_row + 1'b1;
              wr_slot <= (32'(wr_slot) == SLOTS - 1) ? '0 : wr_slot + 1'b1;
              state <= S_RD;
            end
          end else begin
            wc_col <= wc_col + 1'b1;
            state <= S_RD;
          end
        end
        S_MED: begin
          // count now holds n; middle indexes (n-1)/2 and n/2
          if (med_step == 2'd0) begin
            med_step <= 2'd1;
          end else if (med_step == 2'd1) begin
            mid_a <= cv[NW'((count - 1'b1) >> 1)];
            med_step <= 2'd2;
          end else begin
            res_val <= count[0] ? cv[count >> 1] :
                       DIST_W'(({1'b0, mid_a} + {1'b0, cv[count >> 1]}) >> 1);
            state <= S_OUT;
            out_valid <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            budget <= budget - 1'b1;
            if (is_last) begin
              out_row <= '0; out_col <= '0; out_slot <= '0; in_done <= 1'b0;
            end else if (13'(out_col) + 13'd1 >= eff_w) begin
              out_col <= '0; out_row <= out_row + 1'b1;
              out_slot <= (32'(out_slot) == SLOTS - 1) ? '0 : out_slot + 1'b1;
            end else begin
              out_col <= out_col + 1'b1;
            end
            if (!was_pixel || budget == 3'd1 ||
                (!in_done && in_row == 0 && in_col == 0))
              state <= S_IDLE;
            else
              state <= S_CHECK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);
  assign median_distance = res_val;
  assign pixel_row = POS_W'(out_row);
  assign pixel_col = POS_W'(out_col);
  assign frame_last = is_last;

  `WMSD_ASSERT_IMP(a_out_state, out_valid, state == S_OUT)
  `WMSD_ASSERT_IMP(a_no_take_busy, in_ready, !out_valid)
  `WMSD_ASSERT_NEXT(a_hold_res, out_valid && !out_ready, $stable(median_distance))
endmodule
